/* rtl/dasw_pkg.sv */
package dasw_pkg;

  // Request kinds carried by the action field
  typedef enum logic {
    ActTick  = 1'b0,
    ActWrite = 1'b1
  } action_e;

  localparam int unsigned CoilBits   = 4;
  localparam int unsigned PhaseBits  = 3;
  localparam int unsigned SlotBits   = 6;
  localparam int unsigned PortPosBits = 24;
  localparam int unsigned DwellBits  = 10;
  localparam logic [DwellBits-1:0] DwellReset = 10'd100;

  // Half-step coil table, coils 0..3 as bits 0..3
  localparam logic [CoilBits-1:0] HalfStep [8] = '{
    4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
  };

  // One result as it leaves the block
  typedef struct packed {
    logic [CoilBits-1:0]    x_coils;
    logic [CoilBits-1:0]    y_coils;
    logic [PortPosBits-1:0] x_position;
    logic [PortPosBits-1:0] y_position;
    logic [SlotBits-1:0]    next_slot;
    logic                   dwelling;
    logic                   settled;
  } res_t;

  // Drive pattern at a phase, with table coils 1 and 2 swapped onto IN3 and IN2
  function automatic logic [CoilBits-1:0] wire_coils(input logic [PhaseBits-1:0] phase);
    logic [CoilBits-1:0] p;
    p = HalfStep[phase];
    return {p[3], p[1], p[2], p[0]};
  endfunction

endpackage

/* rtl/dual_axis_stepper_waypoint_follower_unit.sv */
// Channel  | Handshake                | Payload
// ---------+--------------------------+-------------------------------------------
// in       | in_valid_i / in_stall_o  | action_i, slot_i, way_x_i, way_y_i
// out      | out_valid_o / out_stall_i| x/y_coils_o, x/y_position_o, next_slot_o,
//          |                          | dwelling_o, settled_o
// cfg      | cfg_we_i                 | cfg_wdata_i (dwell_ticks)
//
// One request per cycle while in_stall_o is low, one result per request, registered in
// the output buffer before out_valid_o shows it. The waypoint word at the slot pointer
// is prefetched from the single-port-read waypoint RAM by a registered read at the next
// pointer, so a tick never waits on the memory. After reset a clearing pass zeroes all
// SLOTS entries (64 by default) with in_stall_o high; cfg writes are taken throughout.
// A two-deep result buffer lets a request enter while one result is held by out_stall_i.
module dual_axis_stepper_waypoint_follower_unit #(
  parameter int unsigned SLOTS    = 64,
  parameter int unsigned POS_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [5:0]  slot_i,
  input  logic [23:0] way_x_i,
  input  logic [23:0] way_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  x_coils_o,
  output logic [3:0]  y_coils_o,
  output logic [23:0] x_position_o,
  output logic [23:0] y_position_o,
  output logic [5:0]  next_slot_o,
  output logic        dwelling_o,
  output logic        settled_o,
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_wdata_i
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned WW = 2 * POS_BITS;

  logic [dasw_pkg::DwellBits-1:0] dwell_ticks_q;
  logic [dasw_pkg::PhaseBits-1:0] x_phase_q, x_phase_d, y_phase_q, y_phase_d;
  logic [dasw_pkg::CoilBits-1:0]  x_latch_q, x_latch_d, y_latch_q, y_latch_d;
  logic [POS_BITS-1:0]            x_pos_q, x_pos_d, y_pos_q, y_pos_d;
  logic [POS_BITS-1:0]            x_goal_q, x_goal_d, y_goal_q, y_goal_d;
  logic [AW-1:0]                  ptr_q, ptr_d;
  logic [dasw_pkg::DwellBits-1:0] dwell_q, dwell_d;
  logic                           clr_q;
  logic [AW-1:0]                  clr_addr_q;
  logic                           fwd_vld_q;
  logic [WW-1:0]                  fwd_data_q;

  logic                accept, is_write, step_en, load;
  logic [31:0]         slot_ext, wx_ext, wy_ext;
  logic [31:0]         xp_ext, yp_ext, ptr_ext;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [WW-1:0]       wr_data;
  logic [WW-1:0]       rd_data, wp;
  logic [POS_BITS-1:0] wp_x, wp_y;
  logic                full;
  dasw_pkg::res_t      res, res_out;

  assign accept   = in_valid_i & ~in_stall_o;
  assign is_write = dasw_pkg::action_e'(action_i) == dasw_pkg::ActWrite;
  assign slot_ext = 32'(slot_i);
  assign wx_ext   = 32'(way_x_i);
  assign wy_ext   = 32'(way_y_i);

  // Clearing pass owns the write port after reset, then waypoint requests
  always_comb begin
    if (clr_q) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_q;
      wr_data = '0;
    end else begin
      wr_en   = accept & is_write & (slot_ext < 32'(SLOTS));
      wr_addr = slot_ext[AW-1:0];
      wr_data = {wy_ext[POS_BITS-1:0], wx_ext[POS_BITS-1:0]};
    end
  end

  dasw_ram #(
    .WIDTH(WW),
    .DEPTH(SLOTS)
  ) u_wp_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .raddr_i(ptr_d),
    .rdata_o(rd_data)
  );

  // Forward a write that hit the prefetched entry in the same cycle
  assign wp   = fwd_vld_q ? fwd_data_q : rd_data;
  assign wp_x = wp[POS_BITS-1:0];
  assign wp_y = wp[WW-1:POS_BITS];

  assign step_en = accept & ~is_write & (dwell_q == '0);

  dasw_axis #(.POS_BITS(POS_BITS)) u_axis_x (
    .en_i   (step_en),
    .pos_i  (x_pos_q),
    .goal_i (x_goal_q),
    .phase_i(x_phase_q),
    .latch_i(x_latch_q),
    .pos_o  (x_pos_d),
    .phase_o(x_phase_d),
    .latch_o(x_latch_d)
  );

  dasw_axis #(.POS_BITS(POS_BITS)) u_axis_y (
    .en_i   (step_en),
    .pos_i  (y_pos_q),
    .goal_i (y_goal_q),
    .phase_i(y_phase_q),
    .latch_i(y_latch_q),
    .pos_o  (y_pos_d),
    .phase_o(y_phase_d),
    .latch_o(y_latch_d)
  );

  // Load the next waypoint once both axes arrive and its x is nonzero, then dwell
  assign load = step_en & (x_pos_d == x_goal_q) & (y_pos_d == y_goal_q) & (wp_x != '0);

  always_comb begin
    x_goal_d = x_goal_q;
    y_goal_d = y_goal_q;
    ptr_d    = ptr_q;
    dwell_d  = dwell_q;
    if (accept && !is_write && (dwell_q != '0)) begin
      dwell_d = dwell_q - 1'b1;
    end else if (load) begin
      x_goal_d = wp_x;
      y_goal_d = wp_y;
      ptr_d    = (ptr_q == AW'(SLOTS - 1)) ? '0 : ptr_q + 1'b1;
      dwell_d  = dwell_ticks_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_ticks_q <= dasw_pkg::DwellReset;
      x_phase_q     <= '0;
      y_phase_q     <= '0;
      x_latch_q     <= '0;
      y_latch_q     <= '0;
      x_pos_q       <= '0;
      y_pos_q       <= '0;
      x_goal_q      <= '0;
      y_goal_q      <= '0;
      ptr_q         <= '0;
      dwell_q       <= '0;
      clr_q         <= 1'b1;
      clr_addr_q    <= '0;
      fwd_vld_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dwell_ticks_q <= cfg_wdata_i;
      end
      x_phase_q <= x_phase_d;
      y_phase_q <= y_phase_d;
      x_latch_q <= x_latch_d;
      y_latch_q <= y_latch_d;
      x_pos_q   <= x_pos_d;
      y_pos_q   <= y_pos_d;
      x_goal_q  <= x_goal_d;
      y_goal_q  <= y_goal_d;
      ptr_q     <= ptr_d;
      dwell_q   <= dwell_d;
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == AW'(SLOTS - 1)) begin
          clr_q <= 1'b0;
        end
      end
      fwd_vld_q <= wr_en & (wr_addr == ptr_d);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wr_data;
  end

  // Assemble the result from the updated state
  assign xp_ext  = 32'(x_pos_d);
  assign yp_ext  = 32'(y_pos_d);
  assign ptr_ext = 32'(ptr_d);

  always_comb begin
    res.x_coils    = x_latch_d;
    res.y_coils    = y_latch_d;
    res.x_position = xp_ext[23:0];
    res.y_position = yp_ext[23:0];
    res.next_slot  = ptr_ext[5:0];
    res.dwelling   = dwell_d != '0;
    res.settled    = (x_pos_d == x_goal_d) & (y_pos_d == y_goal_d);
  end

  dasw_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .res_i      (res),
    .full_o     (full),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .res_o      (res_out)
  );

  assign in_stall_o   = full | clr_q;
  assign x_coils_o    = res_out.x_coils;
  assign y_coils_o    = res_out.y_coils;
  assign x_position_o = res_out.x_position;
  assign y_position_o = res_out.y_position;
  assign next_slot_o  = res_out.next_slot;
  assign dwelling_o   = res_out.dwelling;
  assign settled_o    = res_out.settled;

endmodule

/* rtl/dasw_ram.sv */
module dasw_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port, and registered read that returns the old word on a collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/dasw_axis.sv */
module dasw_axis #(
  parameter int unsigned POS_BITS = 24
) (
  input  logic                               en_i,
  input  logic [POS_BITS-1:0]                pos_i,
  input  logic [POS_BITS-1:0]                goal_i,
  input  logic [dasw_pkg::PhaseBits-1:0]     phase_i,
  input  logic [dasw_pkg::CoilBits-1:0]      latch_i,
  output logic [POS_BITS-1:0]                pos_o,
  output logic [dasw_pkg::PhaseBits-1:0]     phase_o,
  output logic [dasw_pkg::CoilBits-1:0]      latch_o
);

  // Step one position toward the goal, latching the pattern of the old phase
  always_comb begin
    pos_o   = pos_i;
    phase_o = phase_i;
    latch_o = latch_i;
    if (en_i && (pos_i > goal_i)) begin
      latch_o = dasw_pkg::wire_coils(phase_i);
      phase_o = phase_i + 1'b1;
      pos_o   = pos_i - 1'b1;
    end else if (en_i && (pos_i < goal_i)) begin
      latch_o = dasw_pkg::wire_coils(phase_i);
      phase_o = phase_i - 1'b1;
      pos_o   = pos_i + 1'b1;
    end
  end

endmodule

/* rtl/dasw_outbuf.sv */
module dasw_outbuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dasw_pkg::res_t res_i,
  output logic           full_o,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output dasw_pkg::res_t res_o
);

  logic           out_vld_q, out_vld_d;
  logic           skid_vld_q, skid_vld_d;
  dasw_pkg::res_t out_q, out_d;
  dasw_pkg::res_t skid_q, skid_d;
  logic           pop;

  assign pop = out_vld_q & ~out_stall_i;

  // Fill the output stage first, park in the skid stage when it is held
  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (push_i) begin
      if (!out_vld_q || pop) begin
        out_d     = res_i;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = res_i;
        skid_vld_d = 1'b1;
      end
    end else if (pop) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign res_o       = out_q;

endmodule
